FILE: hdl/pbmc_pkg.sv
// shared widths, reset values and struct types for the packed base mismatch counter
// no dependencies; compiled first
package pbmc_pkg;

    localparam int ByteW   = 8;
    localparam int PhaseW  = 2;
    localparam int BasesW  = 3;
    localparam int CountW  = 3;
    localparam int TotalW  = 11;
    localparam int LaneNum = 4;

    localparam logic [BasesW-1:0] BasesFull  = BasesW'(LaneNum);
    localparam logic [TotalW-1:0] LimitReset = TotalW'(4);
    localparam logic [TotalW-1:0] TotalMax   = {TotalW{1'b1}};

    // one accumulation step handed to the accumulator
    typedef struct packed {
        logic              fire;
        logic              last;
        logic [CountW-1:0] count;
    } t_step;

    // running total and sticky over-limit flag
    typedef struct packed {
        logic [TotalW-1:0] mismatches;
        logic              over_limit;
    } t_result;

endpackage

FILE: hdl/pbmc_in_if.sv
// request channel of the counter: valid, ready, a read byte, its window and last flag
// depends on pbmc_pkg
interface pbmc_in_if import pbmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ByteW-1:0]  read_byte;
    logic [ByteW-1:0]  target_byte;
    logic [ByteW-1:0]  target_next_byte;
    logic [PhaseW-1:0] phase;
    logic [BasesW-1:0] bases_valid;
    logic              last;

    modport source (
        output valid, read_byte, target_byte, target_next_byte, phase, bases_valid, last,
        input  ready
    );
    modport sink (
        input  valid, read_byte, target_byte, target_next_byte, phase, bases_valid, last,
        output ready
    );
endinterface

FILE: hdl/pbmc_out_if.sv
// result channel of the counter: valid, ready, the read total and over-limit flag
// depends on pbmc_pkg
interface pbmc_out_if import pbmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TotalW-1:0] mismatches;
    logic              over_limit;

    modport source (output valid, mismatches, over_limit, input ready);
    modport sink   (input valid, mismatches, over_limit, output ready);
endinterface

FILE: hdl/pbmc_lane_count.sv
// window alignment and per-lane mismatch count for one read byte
// depends on pbmc_pkg
module pbmc_lane_count import pbmc_pkg::*; (
    input  logic [ByteW-1:0]  i_read_byte,
    input  logic [ByteW-1:0]  i_target_byte,
    input  logic [ByteW-1:0]  i_target_next_byte,
    input  logic [PhaseW-1:0] i_phase,
    input  logic [BasesW-1:0] i_bases_valid,
    output logic [CountW-1:0] o_count
);

    logic [2*ByteW-1:0] pair_shifted;
    logic [ByteW-1:0]   window;
    logic [ByteW-1:0]   diff;
    logic [BasesW-1:0]  lanes;
    logic [LaneNum-1:0] lane_hit;

    always_comb begin
        pair_shifted = {i_target_byte, i_target_next_byte} << {i_phase, 1'b0};
        window       = pair_shifted[2*ByteW-1:ByteW];
        diff         = i_read_byte ^ window;
        // more than four bases means the full byte
        lanes        = (i_bases_valid > BasesFull) ? BasesFull : i_bases_valid;
        o_count      = '0;
        for (int k = 0; k < LaneNum; k++) begin
            lane_hit[k] = (|diff[ByteW-1-2*k -: 2]) && (BasesW'(k) < lanes);
            o_count     = o_count + CountW'(lane_hit[k]);
        end
    end

endmodule

FILE: hdl/pbmc_accum.sv
// saturating mismatch accumulator with sticky over-limit flag
// depends on pbmc_pkg
module pbmc_accum import pbmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TotalW-1:0] i_limit,
    input  t_step             i_step,
    output t_result           o_next,
    output t_result           o_state
);

    logic [TotalW-1:0] r_total, n_total;
    logic              r_exceeded, n_exceeded;
    logic [TotalW-1:0] cap;
    logic [TotalW:0]   sum;
    logic [TotalW-1:0] sat;
    logic              exc;

    always_comb begin
        cap = (i_limit == TotalMax) ? TotalMax : i_limit + TotalW'(1);
        sum = {1'b0, r_total} + (TotalW+1)'(i_step.count);
        sat = (sum > {1'b0, cap}) ? cap : sum[TotalW-1:0];
        exc = r_exceeded | (sat > i_limit);

        o_next.mismatches  = sat;
        o_next.over_limit  = exc;
        o_state.mismatches = r_total;
        o_state.over_limit = r_exceeded;

        n_total    = r_total;
        n_exceeded = r_exceeded;
        if (i_step.fire) begin
            // the last byte closes the read, the next one starts fresh
            n_total    = i_step.last ? '0 : sat;
            n_exceeded = i_step.last ? 1'b0 : exc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_exceeded <= 1'b0;
        end else begin
            r_total    <= n_total;
            r_exceeded <= n_exceeded;
        end
    end

endmodule

FILE: hdl/packed_base_mismatch_counter.sv
// top level of the packed base mismatch counter
// depends on pbmc_pkg, pbmc_in_if, pbmc_out_if, pbmc_lane_count, pbmc_accum
//
// usage
//   i_in carries one read byte per request: four 2-bit bases (first base in
//   bits 7:6), the two target bytes that hold its window, the base phase of
//   the window start and the number of leading bases to compare. last marks
//   the final byte of a read.
//   o_out carries one request per read, on its last byte: the mismatch total,
//   saturated at mismatch_limit + 1 (at most 2047), and the sticky over-limit flag.
//   i_cfg_we / i_cfg_wdata write mismatch_limit (reset value 4); write it
//   only while no request sits in the input register. a write between two
//   bytes of a read applies to the bytes that follow it.
// timing
//   one request per cycle, except that a last byte waits while o_out holds
//   an untaken result. a request is latched into the input register, then
//   aligned, counted and accumulated; the result of a last byte is then
//   registered in the result register that drives o_out.
// reset and stall
//   synchronous active-low reset clears the limit to 4, the running total,
//   the flag and both valid bits. while o_out is stalled the input register
//   holds at most one more last byte; non-last bytes keep flowing, since they
//   need no output slot.
module packed_base_mismatch_counter import pbmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TotalW-1:0] i_cfg_wdata,
    pbmc_in_if.sink           i_in,
    pbmc_out_if.source        o_out
);

    // configuration register
    logic [TotalW-1:0] r_limit, n_limit;

    // input register stage
    logic              r_s1_valid, n_s1_valid;
    logic [ByteW-1:0]  r_s1_read, r_s1_t0, r_s1_t1;
    logic [PhaseW-1:0] r_s1_phase;
    logic [BasesW-1:0] r_s1_bases;
    logic              r_s1_last;

    // result register stage
    logic              r_out_valid, n_out_valid;
    t_result           r_out;

    logic              s1_advance;
    logic              in_fire;
    logic [CountW-1:0] lane_count;
    t_step             step;
    t_result           acc_next;
    t_result           acc_state;

    // a non-last byte only touches the accumulator, a last byte needs a free
    // output slot (or one that empties this cycle)
    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign in_fire    = i_in.valid && i_in.ready;

    assign step.fire  = s1_advance;
    assign step.last  = r_s1_last;
    assign step.count = lane_count;

    pbmc_lane_count u_lane_count (
        .i_read_byte        (r_s1_read),
        .i_target_byte      (r_s1_t0),
        .i_target_next_byte (r_s1_t1),
        .i_phase            (r_s1_phase),
        .i_bases_valid      (r_s1_bases),
        .o_count            (lane_count)
    );

    pbmc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_limit),
        .i_step  (step),
        .o_next  (acc_next),
        .o_state (acc_state)
    );

    always_comb begin
        n_limit     = i_cfg_we ? i_cfg_wdata : r_limit;
        n_s1_valid  = in_fire ? 1'b1 : (s1_advance ? 1'b0 : r_s1_valid);
        n_out_valid = r_out_valid;
        if (s1_advance && r_s1_last) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LimitReset;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_limit     <= n_limit;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_read  <= i_in.read_byte;
            r_s1_t0    <= i_in.target_byte;
            r_s1_t1    <= i_in.target_next_byte;
            r_s1_phase <= i_in.phase;
            r_s1_bases <= i_in.bases_valid;
            r_s1_last  <= i_in.last;
        end
        if (s1_advance && r_s1_last) begin
            r_out <= acc_next;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.mismatches = r_out.mismatches;
    assign o_out.over_limit = r_out.over_limit;

`ifndef ASSERT_OFF
    // the flag can only be set by a nonzero total
    a_flag_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.over_limit |-> o_out.mismatches != '0)
        else $error("over_limit reported with zero mismatches");

    // closing a read clears the accumulator
    a_read_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.fire && step.last |=> acc_state.mismatches == '0 && !acc_state.over_limit)
        else $error("accumulator not cleared after last byte");

    // a stalled input register keeps its byte
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_advance |=> r_s1_valid && $stable(r_s1_read) && $stable(r_s1_last))
        else $error("input register lost a stalled byte");

    // a last byte only leaves the input register into a free output slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_s1_last |-> !r_out_valid || o_out.ready)
        else $error("result register overwritten");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for packed_base_mismatch_counter: directed table, then random reads
// depends on pbmc_pkg, pbmc_in_if, pbmc_out_if and the counter rtl
module tb_top;
    import pbmc_pkg::*;

    localparam int DrainCycles = 4;
    localparam int StuckLimit  = 2000;  // cycles with no request moving on either side
    localparam int PhaseItems  = 49;    // least number of random bytes per limit setting
    localparam int MaxReports  = 10;

    // one row of stimulus; typed rows carry a hand-written expected total
    typedef struct packed {
        logic [ByteW-1:0]  rd;
        logic [ByteW-1:0]  t0;
        logic [ByteW-1:0]  t1;
        logic [PhaseW-1:0] ph;
        logic [BasesW-1:0] nv;
        logic              last;
        logic              typed;
        logic [TotalW-1:0] want_mm;
        logic              want_over;
    } t_req_row;

    // how the read bytes relate to their target window
    typedef enum int {NearMatch, FullMismatch, Noise} t_read_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [TotalW-1:0] i_cfg_wdata;

    pbmc_in_if  in_bus ();
    pbmc_out_if out_bus ();

    packed_base_mismatch_counter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // mirror of the counter state
    int unsigned limit_now;
    int unsigned read_total;
    bit          read_over;

    // totals owed by the block, oldest first
    t_result read_totals_due [$];

    int  fault_count;
    int  result_count;
    int  stuck_cycles;
    bit  burst_mode;      // both sides stop idling while set
    t_req_row dir_table [22];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // target window: four bases starting ph bases into t0, spilling into t1
    function automatic logic [ByteW-1:0] align_window(logic [ByteW-1:0] t0,
                                                      logic [ByteW-1:0] t1,
                                                      logic [PhaseW-1:0] ph);
        logic [2*ByteW-1:0] pair;
        pair = {t0, t1};
        return pair[2*ByteW-1-2*ph -: ByteW];
    endfunction

    // advance the mirrored read by one accepted byte, owe a total on the last one
    task automatic tally_read_byte(t_req_row row);
        logic [ByteW-1:0] diff;
        int unsigned lanes, hits, cap, sum;
        t_result due;
        lanes = (row.nv > LaneNum) ? LaneNum : row.nv;   // 5..7 compare all four
        diff  = row.rd ^ align_window(row.t0, row.t1, row.ph);
        hits  = 0;
        for (int k = 0; k < LaneNum; k++) begin
            if (k < lanes && diff[ByteW-1-2*k -: 2] != 2'b00) hits++;
        end
        // saturation point is limit + 1, clipped to the 11-bit maximum
        cap = (limit_now + 1 > TotalMax) ? TotalMax : limit_now + 1;
        sum = read_total + hits;
        read_total = (sum > cap) ? cap : sum;
        if (read_total > limit_now) read_over = 1'b1;   // sticky within the read
        if (row.last) begin
            if (row.typed) begin
                due.mismatches = row.want_mm;
                due.over_limit = row.want_over;
            end else begin
                due.mismatches = TotalW'(read_total);
                due.over_limit = read_over;
            end
            read_totals_due.push_back(due);
            read_total = 0;
            read_over  = 1'b0;
        end
    endtask

    // present one request, hold it until the block takes it, then predict
    task automatic send_request(t_req_row row);
        int unsigned gap;
        bit took;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid            <= 1'b1;
        in_bus.read_byte        <= row.rd;
        in_bus.target_byte      <= row.t0;
        in_bus.target_next_byte <= row.t1;
        in_bus.phase            <= row.ph;
        in_bus.bases_valid      <= row.nv;
        in_bus.last             <= row.last;
        // handshake decided at the negedge, taken at the following edge
        do begin
            @(negedge i_clk);
            took = in_bus.valid && in_bus.ready;
            @(posedge i_clk);
        end while (!took);
        tally_read_byte(row);
    endtask

    // limit writes only once every owed total is out and the pipe has drained
    task automatic write_limit(int unsigned value);
        in_bus.valid <= 1'b0;
        while (read_totals_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= TotalW'(value);
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        limit_now = value;
    endtask

    // one read of len bytes, with a fixed phase outside Noise mode; open leaves it without its last byte
    task automatic stream_read(int len, t_read_mode mode, bit open);
        t_req_row row;
        logic [PhaseW-1:0] ph;
        logic [ByteW-1:0] win;
        ph = PhaseW'($urandom_range(0, 3));
        burst_mode = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            row = '0;
            row.t0 = ByteW'($urandom_range(0, 255));
            row.t1 = ByteW'($urandom_range(0, 255));
            row.ph = (mode == Noise) ? PhaseW'($urandom_range(0, 3)) : ph;
            win = align_window(row.t0, row.t1, row.ph);
            row.nv = (i == len - 1) ? BasesW'($urandom_range(1, 4)) : BasesFull;
            row.last = (i == len - 1) && !open;
            case (mode)
                FullMismatch: row.rd = ~win;
                NearMatch: begin
                    // flip roughly one lane in four
                    row.rd = win;
                    for (int k = 0; k < LaneNum; k++) begin
                        if ($urandom_range(0, 3) == 0)
                            row.rd[ByteW-1-2*k -: 2] ^= 2'($urandom_range(1, 3));
                    end
                end
                default: begin
                    row.rd   = ByteW'($urandom_range(0, 255));
                    row.nv   = BasesW'($urandom_range(0, 7));
                    row.last = ($urandom_range(0, 5) == 0) && !open;
                end
            endcase
            send_request(row);
        end
    endtask

    // result side: random stall before each result, ready held until it is taken
    initial begin : result_sink
        int unsigned stall;
        bit took;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = out_bus.valid && out_bus.ready;
                @(posedge i_clk);
            end while (!took);
        end
    end

    // scoreboard: each accepted result against the oldest owed total
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            result_count++;
            if (read_totals_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MaxReports)
                    $display("result %0d with nothing owed: total %0d over %0b",
                             result_count, out_bus.mismatches, out_bus.over_limit);
            end else begin
                want = read_totals_due.pop_front();
                if (out_bus.mismatches !== want.mismatches
                        || out_bus.over_limit !== want.over_limit) begin
                    fault_count++;
                    if (fault_count <= MaxReports)
                        $display("result %0d: expected total %0d over %0b, got total %0d over %0b",
                                 result_count, want.mismatches, want.over_limit,
                                 out_bus.mismatches, out_bus.over_limit);
                end
            end
        end
    end

    // watchdog: no request moving on either channel for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= StuckLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned lim;
        int sent, len;
        t_read_mode mode;
        bit open;

        fault_count  = 0;
        result_count = 0;
        stuck_cycles = 0;
        burst_mode   = 1'b0;
        limit_now    = LimitReset;
        read_total   = 0;
        read_over    = 1'b0;

        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_wdata             <= '0;
        in_bus.valid            <= 1'b0;
        in_bus.read_byte        <= '0;
        in_bus.target_byte      <= '0;
        in_bus.target_next_byte <= '0;
        in_bus.phase            <= '0;
        in_bus.bases_valid      <= '0;
        in_bus.last             <= 1'b0;

        // directed rows, limit at its reset value of 4
        //             rd     t0     t1    ph nv last typed mm over
        dir_table = '{
            '{8'hFF, 8'h00, 8'h00, 0, 4, 1, 1, 4, 0},   // every lane differs
            '{8'h00, 8'h00, 8'hFF, 0, 4, 1, 1, 0, 0},   // phase 0 ignores the next byte
            '{8'hFF, 8'h00, 8'h00, 0, 4, 0, 0, 0, 0},
            '{8'hFF, 8'h00, 8'h00, 0, 4, 1, 1, 5, 1},   // 8 saturates at limit + 1
            '{8'hFF, 8'h00, 8'h00, 0, 0, 1, 1, 0, 0},   // no valid bases
            '{8'hFF, 8'h00, 8'h00, 0, 7, 1, 1, 4, 0},   // too many bases act as four
            '{8'hFF, 8'h00, 8'h00, 0, 5, 1, 1, 4, 0},
            '{8'hFF, 8'h00, 8'h00, 0, 1, 1, 1, 1, 0},   // first base only
            '{8'h55, 8'h00, 8'h00, 0, 4, 1, 1, 4, 0},   // low bit of each lane
            '{8'hAA, 8'h00, 8'h00, 0, 4, 1, 1, 4, 0},   // high bit of each lane
            '{8'hE4, 8'hE4, 8'h00, 0, 4, 1, 1, 0, 0},   // exact match
            '{8'h00, 8'hFF, 8'hFF, 2, 4, 1, 1, 4, 0},
            '{8'h1B, 8'hE4, 8'h39, 1, 4, 1, 0, 0, 0},
            '{8'hC6, 8'h5A, 8'hA5, 2, 3, 1, 0, 0, 0},
            '{8'h3C, 8'h81, 8'h7E, 3, 2, 1, 0, 0, 0},
            '{8'h93, 8'h4E, 8'hD2, 1, 4, 0, 0, 0, 0},   // four byte read at phase 1
            '{8'h2D, 8'hD2, 8'h77, 1, 4, 0, 0, 0, 0},
            '{8'hF0, 8'h77, 8'h0F, 1, 4, 0, 0, 0, 0},
            '{8'h8B, 8'h0F, 8'hC1, 1, 2, 1, 0, 0, 0},
            '{8'hFF, 8'h00, 8'h00, 0, 4, 0, 0, 0, 0},   // the last byte pushes the total over the limit
            '{8'h00, 8'h00, 8'h00, 0, 4, 0, 0, 0, 0},
            '{8'hFF, 8'h00, 8'h00, 0, 1, 1, 1, 5, 1}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            burst_mode = ($urandom_range(0, 2) == 0);
            send_request(dir_table[i]);
        end

        // random reads under a run of limit settings, extremes first
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: lim = 0;
                1: lim = 1024;
                2: lim = TotalMax;
                3: lim = 1;
                4: lim = LimitReset;
                default: lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TotalMax)
                                                           : $urandom_range(0, 24);
            endcase
            write_limit(lim);
            sent = 0;
            while (sent < PhaseItems) begin
                len = $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    0:       mode = Noise;
                    1, 2:    mode = FullMismatch;
                    default: mode = NearMatch;
                endcase
                // sometimes leave the read open so the next limit lands mid-read
                open = (sent + len >= PhaseItems) && ($urandom_range(0, 2) == 0);
                stream_read(len, mode, open);
                sent += len;
            end
        end

        in_bus.valid <= 1'b0;
        while (read_totals_due.size() != 0) @(posedge i_clk);
        repeat (2 * DrainCycles) @(posedge i_clk);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: packed_base_mismatch_counter.f
hdl/pbmc_pkg.sv
hdl/pbmc_in_if.sv
hdl/pbmc_out_if.sv
hdl/pbmc_lane_count.sv
hdl/pbmc_accum.sv
hdl/packed_base_mismatch_counter.sv
tb/sv/tb_top.sv
